// ===== src/lpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants of the LRU page translator.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int ADDR_W      = 24;
  localparam int PSIZE_W     = 16;
  localparam int PAGE_W      = 10;
  localparam int PAGE_SLOTS  = 1 << PAGE_W;
  localparam int FRAME_W     = 5;
  localparam int FRAME_SLOTS = 1 << FRAME_W;
  localparam int FCNT_W      = 6;
  localparam int STAMP_W     = 32;
  localparam int TOTAL_W     = 32;
  localparam int PHYS_W      = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  // reset values of the configuration registers
  localparam logic [PSIZE_W-1:0] PAGE_BYTES_RST    = 16'd1024;
  localparam logic [FCNT_W-1:0]  FRAMES_IN_USE_RST = 6'd4;

  // one split request passed from front to back
  typedef struct packed {
    logic               oor;
    logic [PAGE_W-1:0]  page;
    logic [PSIZE_W-1:0] offset;
    logic [PSIZE_W-1:0] psize;
  } lpt_item_t;

endpackage

// ===== src/lpt_front.sv =====
// ----------------------------------------------------------------------------
// lpt_front
// Accepts a request and splits the address by the page size with a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lpt_pkg::ADDR_W-1:0]       addr,
  input  logic [lpt_pkg::PSIZE_W-1:0]      page_bytes,
  output logic                             front_busy,
  output logic                             push,
  output lpt_pkg::lpt_item_t               push_item,
  input  logic                             queue_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [4:0] LAST_STEP = 5'(lpt_pkg::ADDR_W - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic [lpt_pkg::ADDR_W-1:0]    acc_r, acc_nxt;
  logic [lpt_pkg::PSIZE_W-1:0]   rem_r, rem_nxt;
  logic [lpt_pkg::PSIZE_W-1:0]   div_r, div_nxt;
  logic [lpt_pkg::PSIZE_W:0]     trial;
  logic [lpt_pkg::PSIZE_W:0]     diff;
  logic                          ge;

  // one restoring step
  assign trial = {rem_r, acc_r[lpt_pkg::ADDR_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          acc_nxt   = addr;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          div_nxt   = (page_bytes == '0) ? lpt_pkg::PSIZE_W'(1) : page_bytes;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        acc_nxt = {acc_r[lpt_pkg::ADDR_W-2:0], ge};
        rem_nxt = ge ? diff[lpt_pkg::PSIZE_W-1:0] : trial[lpt_pkg::PSIZE_W-1:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!queue_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // hand the split request to the queue
  assign front_busy       = (state_r != F_IDLE);
  assign push             = (state_r == F_PUSH) && !queue_full;
  assign push_item.oor    = |acc_r[lpt_pkg::ADDR_W-1:lpt_pkg::PAGE_W];
  assign push_item.page   = acc_r[lpt_pkg::PAGE_W-1:0];
  assign push_item.offset = rem_r;
  assign push_item.psize  = div_r;

endmodule

// ===== src/lpt_queue.sv =====
// ----------------------------------------------------------------------------
// lpt_queue
// Two-entry queue between the divider front and the table back.
// ----------------------------------------------------------------------------
module lpt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpt_pkg::lpt_item_t push_item,
  input  logic               pop,
  output lpt_pkg::lpt_item_t head_item,
  output logic               empty,
  output logic               full
);

  lpt_pkg::lpt_item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty     = (cnt_r == 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head_item = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== src/lpt_back.sv =====
// ----------------------------------------------------------------------------
// lpt_back
// Page table lookup, free frame pick, oldest frame scan and result register.
// ----------------------------------------------------------------------------
module lpt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lpt_pkg::FCNT_W-1:0]        frames_in_use,
  input  lpt_pkg::lpt_item_t                head_item,
  input  logic                              empty,
  output logic                              pop,
  output logic                              clearing,
  output logic                              out_valid,
  output logic [lpt_pkg::PAGE_W-1:0]        out_page_number,
  output logic [lpt_pkg::PSIZE_W-1:0]       out_page_offset,
  output logic                              out_was_hit,
  output logic                              out_evicted,
  output logic [lpt_pkg::PAGE_W-1:0]        out_replaced_page,
  output logic [lpt_pkg::FRAME_W-1:0]       out_frame_number,
  output logic [lpt_pkg::PHYS_W-1:0]        out_physical_address,
  output logic                              out_out_of_range,
  output logic [lpt_pkg::TOTAL_W-1:0]       out_hit_total,
  output logic [lpt_pkg::TOTAL_W-1:0]       out_fault_total
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int FW = lpt_pkg::FRAME_W;
  localparam int PW = lpt_pkg::PAGE_W;
  localparam int SW = lpt_pkg::STAMP_W;
  localparam logic [FW-1:0] LAST_FRAME = FW'(lpt_pkg::FRAME_SLOTS - 1);
  localparam logic [PW-1:0] LAST_PAGE  = PW'(lpt_pkg::PAGE_SLOTS - 1);

  logic [2:0]               state_r, state_nxt;
  logic [PW-1:0]            clr_r;
  lpt_pkg::lpt_item_t       item_r;
  logic [SW-1:0]            clock_r;
  logic [lpt_pkg::TOTAL_W-1:0] hits_r, faults_r;
  logic                     hit_r, evict_r, found_r;
  logic [FW-1:0]            frame_r, scan_r;
  logic [SW-1:0]            best_age_r;
  logic [PW-1:0]            best_page_r;

  // per-frame state: busy flag, owning page and last-use stamp
  logic [lpt_pkg::FRAME_SLOTS-1:0] busy_r;
  logic [PW-1:0]            owner_r [lpt_pkg::FRAME_SLOTS];
  logic [SW-1:0]            stamp_r [lpt_pkg::FRAME_SLOTS];

  // page table memory: {valid, frame}
  logic [FW:0]              ptab [lpt_pkg::PAGE_SLOTS];
  logic [FW:0]              rd_data_r;
  logic                     we;
  logic [PW-1:0]            wa;
  logic [FW:0]              wd;

  always_comb begin
    we = 1'b0;
    wa = item_r.page;
    wd = {1'b1, frame_r};
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '0;
      end
      S_EVICT: begin
        we = 1'b1;
        wa = best_page_r;
        wd = '0;
      end
      S_FILL:  we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ptab[wa] <= wd;
    end
    rd_data_r <= ptab[head_item.page];
  end

  // usable frame count, clamped to 1..FRAME_SLOTS
  logic [lpt_pkg::FCNT_W-1:0] usable;
  logic                       free_hit;
  logic [FW-1:0]              free_idx;

  always_comb begin
    if (frames_in_use == '0) begin
      usable = lpt_pkg::FCNT_W'(1);
    end else if (frames_in_use > lpt_pkg::FCNT_W'(lpt_pkg::FRAME_SLOTS)) begin
      usable = lpt_pkg::FCNT_W'(lpt_pkg::FRAME_SLOTS);
    end else begin
      usable = frames_in_use;
    end
  end

  // lowest free frame below the usable count
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = lpt_pkg::FRAME_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i] && (lpt_pkg::FCNT_W'(i) < usable)) begin
        free_hit = 1'b1;
        free_idx = FW'(i);
      end
    end
  end

  // age of the scanned frame and whether it beats the best so far
  logic [SW-1:0] age;
  logic          better;
  assign age    = clock_r - stamp_r[scan_r];
  assign better = busy_r[scan_r] && (!found_r || (age > best_age_r) ||
                  ((age == best_age_r) && (owner_r[scan_r] < best_page_r)));

  assign pop      = (state_r == S_IDLE) && !empty;
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == LAST_PAGE) state_nxt = S_IDLE;
      S_IDLE:  if (!empty) state_nxt = head_item.oor ? S_OUT : S_LOOK;
      S_LOOK: begin
        if (rd_data_r[FW])  state_nxt = S_OUT;
        else if (free_hit)  state_nxt = S_FILL;
        else                state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_r == LAST_FRAME) begin
          state_nxt = (found_r || better) ? S_EVICT : S_FILL;
        end
      end
      S_EVICT: state_nxt = S_FILL;
      S_FILL:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      clock_r   <= '0;
      hits_r    <= '0;
      faults_r  <= '0;
      busy_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_OUT);
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + PW'(1);
      end
      if (state_r == S_LOOK) begin
        clock_r <= clock_r + SW'(1);
        if (rd_data_r[FW]) begin
          hits_r <= hits_r + lpt_pkg::TOTAL_W'(1);
        end else begin
          faults_r <= faults_r + lpt_pkg::TOTAL_W'(1);
        end
      end
      if (state_r == S_FILL) begin
        busy_r[frame_r] <= 1'b1;
      end
    end
  end

  // item handling datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r  <= head_item;
      hit_r   <= 1'b0;
      evict_r <= 1'b0;
      frame_r <= '0;
    end
    unique case (state_r)
      S_LOOK: begin
        scan_r  <= '0;
        found_r <= 1'b0;
        if (rd_data_r[FW]) begin
          hit_r   <= 1'b1;
          frame_r <= rd_data_r[FW-1:0];
          stamp_r[rd_data_r[FW-1:0]] <= clock_r + SW'(1);
        end else if (free_hit) begin
          frame_r <= free_idx;
        end
      end
      S_SCAN: begin
        scan_r <= scan_r + FW'(1);
        if (better) begin
          found_r     <= 1'b1;
          best_age_r  <= age;
          best_page_r <= owner_r[scan_r];
          frame_r     <= scan_r;
        end
      end
      S_EVICT: evict_r <= 1'b1;
      S_FILL: begin
        owner_r[frame_r] <= item_r.page;
        stamp_r[frame_r] <= clock_r;
      end
      default: ;
    endcase
  end

  // result register
  logic [PW-1:0] page_o;
  logic [FW-1:0] frame_o;
  assign page_o  = item_r.oor ? '0 : item_r.page;
  assign frame_o = item_r.oor ? '0 : frame_r;

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_page_number      <= page_o;
      out_page_offset      <= item_r.offset;
      out_was_hit          <= hit_r && !item_r.oor;
      out_evicted          <= evict_r && !item_r.oor;
      out_replaced_page    <= (evict_r && !item_r.oor) ? best_page_r : '0;
      out_frame_number     <= frame_o;
      out_physical_address <= item_r.oor ? '0 :
        lpt_pkg::PHYS_W'(frame_o * item_r.psize + {5'd0, item_r.offset});
      out_out_of_range     <= item_r.oor;
      out_hit_total        <= hits_r;
      out_fault_total      <= faults_r;
    end
  end

endmodule

// ===== src/lru_page_translator_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_translator_unit
// LRU page translator: address split, page table lookup and LRU replacement.
// ----------------------------------------------------------------------------
// The address split is a restoring divider giving one bit per cycle; the back
// end then reads the page table memory and, when no frame is free, scans the
// 32 frame stamps one per cycle. A two-entry queue lets the divider work on the
// next request during the back end's table work. busy is high while a request
// is in the divider or waiting to enter the queue, and after reset while the
// page table is cleared. Each result shows for one cycle with out_valid; the
// receiver cannot stall it. cfg_ready is always high; write only while idle.
module lru_page_translator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lpt_pkg::ADDR_W-1:0]           in_logical_address,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpt_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  output logic [lpt_pkg::PAGE_W-1:0]           out_page_number,
  output logic [lpt_pkg::PSIZE_W-1:0]          out_page_offset,
  output logic                                 out_was_hit,
  output logic                                 out_evicted,
  output logic [lpt_pkg::PAGE_W-1:0]           out_replaced_page,
  output logic [lpt_pkg::FRAME_W-1:0]          out_frame_number,
  output logic [lpt_pkg::PHYS_W-1:0]           out_physical_address,
  output logic                                 out_out_of_range,
  output logic [lpt_pkg::TOTAL_W-1:0]          out_hit_total,
  output logic [lpt_pkg::TOTAL_W-1:0]          out_fault_total
);

  logic [lpt_pkg::PSIZE_W-1:0] page_bytes_r;
  logic [lpt_pkg::FCNT_W-1:0]  frames_r;
  logic                        front_busy, clearing;
  logic                        push, pop, q_empty, q_full;
  lpt_pkg::lpt_item_t          push_item, head_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r <= lpt_pkg::PAGE_BYTES_RST;
      frames_r     <= lpt_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpt_pkg::CFG_PAGE_BYTES:    page_bytes_r <= cfg_data;
        lpt_pkg::CFG_FRAMES_IN_USE: frames_r <= cfg_data[lpt_pkg::FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = front_busy || clearing;

  lpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start && !clearing),
    .addr       (in_logical_address),
    .page_bytes (page_bytes_r),
    .front_busy (front_busy),
    .push       (push),
    .push_item  (push_item),
    .queue_full (q_full)
  );

  lpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  lpt_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .frames_in_use        (frames_r),
    .head_item            (head_item),
    .empty                (q_empty),
    .pop                  (pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_page_number      (out_page_number),
    .out_page_offset      (out_page_offset),
    .out_was_hit          (out_was_hit),
    .out_evicted          (out_evicted),
    .out_replaced_page    (out_replaced_page),
    .out_frame_number     (out_frame_number),
    .out_physical_address (out_physical_address),
    .out_out_of_range     (out_out_of_range),
    .out_hit_total        (out_hit_total),
    .out_fault_total      (out_fault_total)
  );

  // results never come back to back
  a_out_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

  // an out-of-range request reports no hit, eviction or frame
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (!out_was_hit && !out_evicted && out_frame_number == '0))
    else $error("out-of-range result carries translation");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_hit) |-> !out_evicted)
    else $error("hit with eviction");

  // nothing leaves the queue while the page table is being cleared
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop) else $error("request taken during clear");

endmodule
